// ===== rtl/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbe_pkg: shared constants for the Mandelbrot escape-time counter
// Field widths, reset value of the iteration limit and parameter defaults.
// ----------------------------------------------------------------------------
package mbe_pkg;

    localparam int ITER_W        = 20;        // max_iterations and result fields
    localparam int C_W           = 32;        // c_real / c_imag
    localparam int COUNT_W_DEF   = 20;
    localparam int FRAC_BITS_DEF = 28;

    localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(1000000);

endpackage

// ===== rtl/mandelbrot_escape_time.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time: escape-time counter with per-frame min/max
// Iterates z = z*z + c from z = 0 on one shared multiplier and reports the
// iteration count plus the running minimum and maximum count of the frame.
// ----------------------------------------------------------------------------
//
//  channel   dir  transaction moves                      tdata / tuser bits
//  s_axis    in   one point c                            [31:0] c_real, [63:32] c_imag
//                                                        tuser: new_frame
//  m_axis    out  one result per point                   [19:0] escape_count,
//                                                        [39:20] min_count,
//                                                        [59:40] max_count
//  cfg       in   max_iterations write                   cfg_data[19:0]
//
//  Each iteration tests for escape, forms three products on the shared
//  multiplier (ax*ax, ay*ay, ax*ay) and then does one z update.
//  s_axis_tready is high only between points; a finished result waits in the
//  output register and the next point is accepted meanwhile.
//  A stalled m_axis holds the next result in the final step until the output
//  register frees. Reset (aresetn low, synchronous) sets max_iterations to
//  1000000, the frame minimum to all ones and the frame maximum to zero.
//
module mandelbrot_escape_time
    import mbe_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_W_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [63:0]       s_axis_tdata,   // [31:0] c_real, [63:32] c_imag
    input  logic              s_axis_tuser,   // [0] new_frame

    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [63:0]       m_axis_tdata,   // [19:0] escape_count, [39:20] min_count,
                                              // [59:40] max_count, [63:60] zero

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ITER_W-1:0] cfg_data        // [19:0] max_iterations
);

    // z width: |z| stays below 2^(FRAC_BITS+2) + 2^31
    localparam int ZB = (FRAC_BITS + 2 > C_W - 1) ? FRAC_BITS + 2 : C_W - 1;
    localparam int ZW = ZB + 2;
    localparam int MW = FRAC_BITS + 2;     // multiplier operand, |z| <= 2^(F+1)
    localparam int PW = 2 * MW;            // product
    localparam int XW = FRAC_BITS + 3;     // truncated square
    localparam int SW = FRAC_BITS + 4;     // sum of squares

    localparam logic [ZW-1:0] LIM  = ZW'(2) << FRAC_BITS;
    localparam logic [SW-1:0] LIM2 = SW'(4) << FRAC_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TEST = 3'd1;
    localparam logic [2:0] S_MYY  = 3'd2;
    localparam logic [2:0] S_MXY  = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]               state_reg, state_next;
    logic [ITER_W-1:0]        max_iter_reg;
    logic signed [C_W-1:0]    cr_reg, ci_reg;
    logic signed [ZW-1:0]     x_reg, x_next, y_reg, y_next;
    logic [ITER_W-1:0]        n_reg, n_next;
    logic [PW-1:0]            p_reg;
    logic [XW-1:0]            xx_reg, xx_next, yy_reg, yy_next;
    logic [COUNT_WIDTH-1:0]   fmin_reg, fmin_next, fmax_reg, fmax_next;
    logic                     m_valid_reg, m_valid_next;
    logic [ITER_W-1:0]        o_cnt_reg, o_min_reg, o_max_reg;

    logic [ZW-1:0]            ax, ay, xy;
    logic [MW-1:0]            mul_a, mul_b;
    logic [XW-1:0]            yy_c;
    logic [COUNT_WIDTH-1:0]   step;
    logic                     s_acc, out_load, stop_mag;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    assign ax       = x_reg[ZW-1] ? ZW'(-x_reg) : ZW'(x_reg);
    assign ay       = y_reg[ZW-1] ? ZW'(-y_reg) : ZW'(y_reg);
    assign stop_mag = (ax > LIM) || (ay > LIM);

    // shared multiplier: ax*ax, then ay*ay, then ax*ay
    assign mul_a = (state_reg == S_MYY) ? MW'(ay) : MW'(ax);
    assign mul_b = (state_reg == S_TEST) ? MW'(ax) : MW'(ay);

    assign yy_c = XW'(p_reg >> FRAC_BITS);
    assign xy   = ZW'(p_reg >> (FRAC_BITS - 1));   // floor(2*ax*ay / 2^F)
    assign step = COUNT_WIDTH'(n_reg);

    assign out_load = (state_reg == S_FIN) && (!m_valid_reg || m_axis_tready);

    always_comb begin
        state_next   = state_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        n_next       = n_reg;
        xx_next      = xx_reg;
        yy_next      = yy_reg;
        fmin_next    = fmin_reg;
        fmax_next    = fmax_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    x_next     = '0;
                    y_next     = '0;
                    n_next     = '0;
                    state_next = S_TEST;
                    if (s_axis_tuser) begin
                        fmin_next = '1;
                        fmax_next = '0;
                    end
                end
            end
            S_TEST: begin
                if (n_reg >= max_iter_reg || stop_mag) begin
                    state_next = S_FIN;
                end else begin
                    state_next = S_MYY;
                end
            end
            S_MYY: begin
                xx_next    = XW'(p_reg >> FRAC_BITS);
                state_next = S_MXY;
            end
            S_MXY: begin
                if (SW'(xx_reg) + SW'(yy_c) > LIM2) begin
                    state_next = S_FIN;
                end else begin
                    yy_next    = yy_c;
                    state_next = S_UPD;
                end
            end
            S_UPD: begin
                x_next = ZW'(xx_reg) - ZW'(yy_reg) + ZW'(cr_reg);
                y_next = ((x_reg[ZW-1] ^ y_reg[ZW-1]) ? -xy : xy) + ZW'(ci_reg);
                n_next = n_reg + ITER_W'(1);
                state_next = S_TEST;
            end
            S_FIN: begin
                // hold the result until the output register frees
                if (out_load) begin
                    if (step < fmin_reg) fmin_next = step;
                    if (step > fmax_reg) fmax_next = step;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            max_iter_reg <= MAX_ITER_RST;
            x_reg        <= '0;
            y_reg        <= '0;
            n_reg        <= '0;
            fmin_reg     <= '1;
            fmax_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            n_reg       <= n_next;
            fmin_reg    <= fmin_next;
            fmax_reg    <= fmax_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                max_iter_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        p_reg  <= PW'(mul_a) * PW'(mul_b);
        xx_reg <= xx_next;
        yy_reg <= yy_next;
        if (s_acc) begin
            cr_reg <= s_axis_tdata[31:0];
            ci_reg <= s_axis_tdata[63:32];
        end
        if (out_load) begin
            o_cnt_reg <= ITER_W'(step);
            o_min_reg <= ITER_W'(fmin_next);
            o_max_reg <= ITER_W'(fmax_next);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0, o_max_reg, o_min_reg, o_cnt_reg};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> (state_reg == S_TEST) && (n_reg == '0) && (x_reg == '0) && (y_reg == '0))
        else $error("point did not start from z = 0");

    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (o_min_reg <= o_cnt_reg) && (o_cnt_reg <= o_max_reg))
        else $error("result count outside frame min/max");

    a_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(state_reg) == S_FIN)
        else $error("result raised outside final step");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPD) |=> !s_axis_tready && (state_reg == S_TEST))
        else $error("update step did not return to escape test");

endmodule
